[sv/jrr_pkg.sv]
`timescale 1ns / 1ps

package jrr_pkg;

    typedef enum logic [1:0] {
        MODE_GUIDING    = 2'd0,
        MODE_WAITING    = 2'd1,
        MODE_RECOVERING = 2'd2
    } mode_t;

    localparam int unsigned TOL_W   = 16;
    localparam int unsigned DIST_W  = 24;
    localparam int unsigned PROD_W  = TOL_W + DIST_W;
    localparam int unsigned THR_W   = 32;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned WAIT_W  = 16;
    localparam int unsigned MINF_W  = 8;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned ADDR_W  = 5;

    localparam logic [2:0] REG_JUMP_EN    = 3'd0;
    localparam logic [2:0] REG_JUMP_TOL   = 3'd1;
    localparam logic [2:0] REG_FORCED_TOL = 3'd2;
    localparam logic [2:0] REG_WAIT_MS    = 3'd3;
    localparam logic [2:0] REG_MIN_FRAMES = 3'd4;

    localparam logic [TOL_W-1:0]  JUMP_TOL_RST   = 16'd1024;
    localparam logic [TOL_W-1:0]  FORCED_TOL_RST = 16'd512;
    localparam logic [WAIT_W-1:0] WAIT_MS_RST    = 16'd5000;
    localparam logic [MINF_W-1:0] MIN_FRAMES_RST = 8'd10;

    localparam logic OP_CHECK    = 1'b0;
    localparam logic OP_ACTIVATE = 1'b1;

endpackage

[sv/jump_reject_recovery_fsm.sv]
`timescale 1ns / 1ps

// Jump-reject gate for a guiding loop. Each input transfer is either a frame check
// (op 0) or an activate event after star loss (op 1); each gives exactly one result.
// A check forms threshold = tolerance * avg_distance (Q8.8 x Q16.8 truncated to Q24.8),
// calls the offset large when distance exceeds it with valid statistics and a finite
// tolerance, and steps a guiding / waiting / recovering machine that decides whether
// the frame is accepted. Items pass through an input register and a result register:
// one item per cycle sustained while m_ready is high, the 16x24 multiply and the state
// update between the two registers. A result held by m_ready low stalls s_ready.
// Registers sit on an APB port at byte addresses
// 0x00 enable, 0x04 jump tolerance, 0x08 forced tolerance, 0x0C wait interval,
// 0x10 minimum statistics frames; write them only while the block is idle.
module jump_reject_recovery_fsm #(
    parameter int unsigned TIME_WIDTH = 48
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [jrr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [TIME_WIDTH-1:0]      s_now_ms,
    input  logic [23:0]                s_distance,
    input  logic [23:0]                s_avg_distance,
    input  logic                       s_guiding_active,
    input  logic                       s_paused,
    input  logic                       s_settling,
    input  logic [15:0]                s_error_frame_count,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_frame_accepted,
    output logic [1:0]                 m_recovery_state,
    output logic                       m_stats_valid,
    output logic [31:0]                m_threshold
);
    import jrr_pkg::*;

    // configuration
    logic              jump_en_reg;
    logic [TOL_W-1:0]  jump_tol_reg;
    logic [TOL_W-1:0]  forced_tol_reg;
    logic [WAIT_W-1:0] wait_ms_reg;
    logic [MINF_W-1:0] min_frames_reg;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jump_en_reg    <= 1'b0;
            jump_tol_reg   <= JUMP_TOL_RST;
            forced_tol_reg <= FORCED_TOL_RST;
            wait_ms_reg    <= WAIT_MS_RST;
            min_frames_reg <= MIN_FRAMES_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_JUMP_EN:    jump_en_reg    <= pwdata[0];
                REG_JUMP_TOL:   jump_tol_reg   <= pwdata[TOL_W-1:0];
                REG_FORCED_TOL: forced_tol_reg <= pwdata[TOL_W-1:0];
                REG_WAIT_MS:    wait_ms_reg    <= pwdata[WAIT_W-1:0];
                REG_MIN_FRAMES: min_frames_reg <= pwdata[MINF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_JUMP_EN:    prdata = {31'd0, jump_en_reg};
            REG_JUMP_TOL:   prdata = {16'd0, jump_tol_reg};
            REG_FORCED_TOL: prdata = {16'd0, forced_tol_reg};
            REG_WAIT_MS:    prdata = {16'd0, wait_ms_reg};
            REG_MIN_FRAMES: prdata = {24'd0, min_frames_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // input register
    logic                  in_valid_reg;
    logic                  in_op_reg;
    logic [TIME_WIDTH-1:0] in_now_reg;
    logic [DIST_W-1:0]     in_dist_reg;
    logic [DIST_W-1:0]     in_avg_reg;
    logic                  in_guiding_reg;
    logic                  in_paused_reg;
    logic                  in_settling_reg;
    logic [FRAME_W-1:0]    in_frames_reg;
    logic                  advance;

    assign advance = in_valid_reg & (~m_valid | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg       <= s_op;
            in_now_reg      <= s_now_ms;
            in_dist_reg     <= s_distance;
            in_avg_reg      <= s_avg_distance;
            in_guiding_reg  <= s_guiding_active;
            in_paused_reg   <= s_paused;
            in_settling_reg <= s_settling;
            in_frames_reg   <= s_error_frame_count;
        end
    end

    // threshold and offset classification
    logic [TOL_W-1:0]  tol;
    logic [PROD_W-1:0] prod;
    logic [THR_W-1:0]  thr;
    logic              stats_ok;
    logic              finite_tol;
    logic              small_off;
    logic [THR_W-1:0]  thr_out;

    mode_t                 mode_reg, mode_next;
    logic [TIME_WIDTH-1:0] deadline_reg, deadline_next;
    logic                  force_reg, force_next;
    logic [TIME_WIDTH-1:0] new_deadline;
    logic                  accepted;

    assign tol        = force_reg ? forced_tol_reg : jump_tol_reg;
    assign prod       = PROD_W'(tol) * PROD_W'(in_avg_reg);
    assign thr        = prod[PROD_W-1:FRAC_W];
    assign finite_tol = force_reg | jump_en_reg;
    assign stats_ok   = in_guiding_reg & ~in_paused_reg & ~in_settling_reg
                      & (in_frames_reg >= FRAME_W'(min_frames_reg));
    assign small_off  = ~(stats_ok & finite_tol & (THR_W'(in_dist_reg) > thr));

    always_comb begin
        if (!stats_ok || in_op_reg == OP_ACTIVATE) begin
            thr_out = '0;
        end else if (finite_tol) begin
            thr_out = thr;
        end else begin
            thr_out = '1;
        end
    end

    assign new_deadline = in_now_reg + TIME_WIDTH'(wait_ms_reg);

    // next state
    always_comb begin
        mode_next     = mode_reg;
        deadline_next = deadline_reg;
        force_next    = force_reg;
        if (in_op_reg == OP_ACTIVATE) begin
            if (mode_reg != MODE_WAITING && mode_reg != MODE_RECOVERING) begin
                mode_next     = MODE_WAITING;
                deadline_next = new_deadline;
                force_next    = 1'b1;
            end
        end else begin
            case (mode_reg)
                MODE_WAITING: begin
                    if (small_off) begin
                        mode_next  = MODE_GUIDING;
                        force_next = 1'b0;
                    end else if (in_now_reg >= deadline_reg) begin
                        mode_next = MODE_RECOVERING;
                    end
                end
                MODE_RECOVERING: begin
                    if (small_off) begin
                        mode_next = MODE_GUIDING;
                    end
                end
                default: begin
                    // guiding, and the unused code treated the same way
                    if (!small_off) begin
                        mode_next     = MODE_WAITING;
                        deadline_next = new_deadline;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        accepted = 1'b1;
        if (in_op_reg == OP_CHECK) begin
            case (mode_reg)
                MODE_WAITING:    accepted = small_off | (in_now_reg >= deadline_reg);
                MODE_RECOVERING: accepted = 1'b1;
                default:         accepted = small_off;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_GUIDING;
            deadline_reg <= '0;
            force_reg    <= 1'b0;
        end else if (advance) begin
            mode_reg     <= mode_next;
            deadline_reg <= deadline_next;
            force_reg    <= force_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_frame_accepted <= accepted;
            m_recovery_state <= mode_next;
            m_stats_valid    <= stats_ok & (in_op_reg == OP_CHECK);
            m_threshold      <= thr_out;
        end
    end

    // a rejected frame only happens while waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_accepted |-> m_recovery_state == MODE_WAITING)
        else $error("rejected frame outside waiting state");

    // without valid statistics the threshold must read zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_stats_valid |-> m_threshold == '0)
        else $error("nonzero threshold without valid statistics");

    // an activate item is always accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg == OP_ACTIVATE |=> m_frame_accepted && !m_stats_valid)
        else $error("activate result not accepted");

    // forced tolerance is only switched on together with a wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(force_reg) |-> mode_reg == MODE_WAITING)
        else $error("forced tolerance set outside waiting state");

endmodule

[test/jump_reject_recovery_fsm_test.sv]
`timescale 1ns / 1ps

module jump_reject_recovery_fsm_test;
    import jrr_pkg::*;

    localparam int unsigned TIME_W = 48;
    localparam int unsigned LATENCY = 4;

    typedef struct {
        logic              op;
        logic [TIME_W-1:0] now;
        logic [23:0]       offset;
        logic [23:0]       avg;
        logic              guiding;
        logic              paused;
        logic              settling;
        logic [15:0]       frames;
    } gate_item_t;

    typedef struct {
        logic        accepted;
        logic [1:0]  state;
        logic        valid;
        logic [31:0] thr;
    } gate_verdict_t;

    class gate_scoreboard;
        logic              jump_en;
        logic [15:0]       jump_tol;
        logic [15:0]       forced_tol;
        logic [15:0]       wait_ms;
        logic [7:0]        min_frames;
        mode_t             mode;
        logic [TIME_W-1:0] deadline;
        logic              force_on;
        gate_verdict_t     expected_verdicts[$];
        int unsigned       errors;

        function new();
            jump_en    = 1'b0;
            jump_tol   = JUMP_TOL_RST;
            forced_tol = FORCED_TOL_RST;
            wait_ms    = WAIT_MS_RST;
            min_frames = MIN_FRAMES_RST;
            mode       = MODE_GUIDING;
            deadline   = '0;
            force_on   = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_JUMP_EN:    jump_en    = val[0];
                REG_JUMP_TOL:   jump_tol   = val[15:0];
                REG_FORCED_TOL: forced_tol = val[15:0];
                REG_WAIT_MS:    wait_ms    = val[15:0];
                REG_MIN_FRAMES: min_frames = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] get_reg(logic [2:0] idx);
            case (idx)
                REG_JUMP_EN:    return {31'd0, jump_en};
                REG_JUMP_TOL:   return {16'd0, jump_tol};
                REG_FORCED_TOL: return {16'd0, forced_tol};
                REG_WAIT_MS:    return {16'd0, wait_ms};
                REG_MIN_FRAMES: return {24'd0, min_frames};
                default:        return 32'd0;
            endcase
        endfunction

        // steps the gate for one accepted item and queues its verdict
        function void note_item(gate_item_t it);
            gate_verdict_t v;
            logic [15:0]   tol;
            logic [39:0]   prod;
            logic          is_small;
            v.accepted = 1'b1;
            v.valid    = 1'b0;
            v.thr      = '0;
            if (it.op == OP_ACTIVATE) begin
                if (mode != MODE_WAITING && mode != MODE_RECOVERING) begin
                    mode     = MODE_WAITING;
                    deadline = it.now + TIME_W'(wait_ms);
                    force_on = 1'b1;
                end
            end else begin
                is_small = 1'b1;
                if (it.guiding && !it.paused && !it.settling &&
                    it.frames >= {8'd0, min_frames}) begin
                    v.valid = 1'b1;
                    if (force_on || jump_en) begin
                        tol      = force_on ? forced_tol : jump_tol;
                        prod     = 40'(tol) * 40'(it.avg);
                        v.thr    = prod[39:8];
                        is_small = !({8'd0, it.offset, 8'd0} > prod);
                    end else begin
                        // infinite tolerance
                        v.thr = 32'hFFFF_FFFF;
                    end
                end
                case (mode)
                    MODE_WAITING: begin
                        if (is_small) begin
                            mode     = MODE_GUIDING;
                            force_on = 1'b0;
                        end else if (it.now < deadline) begin
                            v.accepted = 1'b0;
                        end else begin
                            mode = MODE_RECOVERING;
                        end
                    end
                    MODE_RECOVERING: begin
                        if (is_small) mode = MODE_GUIDING;
                    end
                    default: begin
                        if (!is_small) begin
                            mode       = MODE_WAITING;
                            deadline   = it.now + TIME_W'(wait_ms);
                            v.accepted = 1'b0;
                        end
                    end
                endcase
            end
            v.state = mode;
            expected_verdicts = {expected_verdicts, v};
        endfunction

        function void check_result(gate_verdict_t got);
            gate_verdict_t want;
            if (expected_verdicts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display({"unexpected result transfer: ",
                              "acc=%0b state=%0d valid=%0b thr=%h"},
                             got.accepted, got.state, got.valid, got.thr);
                return;
            end
            want = expected_verdicts[0];
            expected_verdicts.delete(0);
            if (got.accepted !== want.accepted || got.state !== want.state ||
                got.valid !== want.valid || got.thr !== want.thr) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch at %0t: exp acc=%0b state=%0d valid=%0b thr=%h, ",
                              "got acc=%0b state=%0d valid=%0b thr=%h"},
                             $realtime, want.accepted, want.state, want.valid, want.thr,
                             got.accepted, got.state, got.valid, got.thr);
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    wire  [31:0]       prdata;
    wire               pready;
    logic              s_valid;
    wire               s_ready;
    logic              s_op;
    logic [TIME_W-1:0] s_now_ms;
    logic [23:0]       s_distance;
    logic [23:0]       s_avg_distance;
    logic              s_guiding_active;
    logic              s_paused;
    logic              s_settling;
    logic [15:0]       s_error_frame_count;
    wire               m_valid;
    logic              m_ready;
    wire               m_frame_accepted;
    wire  [1:0]        m_recovery_state;
    wire               m_stats_valid;
    wire  [31:0]       m_threshold;

    gate_scoreboard    sb = new();
    logic [TIME_W-1:0] clock_ms;
    logic              no_idle;
    gate_item_t        seen_item;
    gate_verdict_t     seen_verdict;

    jump_reject_recovery_fsm #(
        .TIME_WIDTH(TIME_W)
    ) u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_now_ms            (s_now_ms),
        .s_distance          (s_distance),
        .s_avg_distance      (s_avg_distance),
        .s_guiding_active    (s_guiding_active),
        .s_paused            (s_paused),
        .s_settling          (s_settling),
        .s_error_frame_count (s_error_frame_count),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_frame_accepted    (m_frame_accepted),
        .m_recovery_state    (m_recovery_state),
        .m_stats_valid       (m_stats_valid),
        .m_threshold         (m_threshold)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // transfers on both channels, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_verdict.accepted = m_frame_accepted;
                seen_verdict.state    = m_recovery_state;
                seen_verdict.valid    = m_stats_valid;
                seen_verdict.thr      = m_threshold;
                sb.check_result(seen_verdict);
            end
            if (s_valid && s_ready) begin
                seen_item.op       = s_op;
                seen_item.now      = s_now_ms;
                seen_item.offset   = s_distance;
                seen_item.avg      = s_avg_distance;
                seen_item.guiding  = s_guiding_active;
                seen_item.paused   = s_paused;
                seen_item.settling = s_settling;
                seen_item.frames   = s_error_frame_count;
                sb.note_item(seen_item);
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 50);
    endfunction

    initial begin : result_sink
        int unsigned hold;
        logic        level;
        hold  = 0;
        level = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold == 0) begin
                if (no_idle || $urandom_range(0, 1)) begin
                    level = 1'b1;
                    hold  = $urandom_range(1, 12);
                end else begin
                    level = 1'b0;
                    hold  = 1 + idle_len();
                end
            end
            hold--;
            m_ready <= level;
        end
    end

    function automatic gate_item_t mk(logic op, logic [TIME_W-1:0] now, logic [23:0] offset,
                                      logic [23:0] avg, logic g, logic p, logic s,
                                      logic [15:0] f);
        gate_item_t it;
        it.op = op; it.now = now; it.offset = offset; it.avg = avg;
        it.guiding = g; it.paused = p; it.settling = s; it.frames = f;
        return it;
    endfunction

    function automatic gate_item_t rand_item();
        gate_item_t  it;
        int unsigned r;
        logic [15:0] tol;
        logic [39:0] prod;
        longint      target;
        longint      d;
        r = $urandom_range(0, 99);
        it.op = (r < 6) ? OP_ACTIVATE : OP_CHECK;
        r = $urandom_range(0, 99);
        if (r < 3)       clock_ms = TIME_W'({$urandom, $urandom});
        else if (r < 5)  clock_ms = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3000));
        else if (r < 15) clock_ms = clock_ms + TIME_W'($urandom_range(2000, 70000));
        else             clock_ms = clock_ms + TIME_W'($urandom_range(0, 1500));
        it.now = clock_ms;
        if ($urandom_range(0, 99) < 15) begin
            // noise: any status, any values
            it.offset   = 24'($urandom);
            it.avg      = 24'($urandom);
            it.guiding  = 1'($urandom_range(0, 1));
            it.paused   = 1'($urandom_range(0, 1));
            it.settling = 1'($urandom_range(0, 1));
            it.frames   = 16'($urandom);
            return it;
        end
        it.guiding  = 1'b1;
        it.paused   = 1'b0;
        it.settling = 1'b0;
        it.frames   = ($urandom_range(0, 9) == 0) ? {8'd0, sb.min_frames}
                                                   : 16'($urandom_range(sb.min_frames, 65535));
        r = $urandom_range(0, 99);
        if (r < 10)      it.avg = '0;
        else if (r < 20) it.avg = 24'hFF_FFFF;
        else if (r < 60) it.avg = 24'($urandom_range(1, 4096));
        else             it.avg = 24'($urandom);
        tol    = (sb.force_on || $urandom_range(0, 3) == 0) ? sb.forced_tol : sb.jump_tol;
        prod   = 40'(tol) * 40'(it.avg);
        target = longint'(prod[39:8]);
        r = $urandom_range(0, 99);
        if (r < 40) begin
            d = target + longint'($urandom_range(0, 6)) - 3;
            if (d < 0) d = 0;
            if (d > 24'hFF_FFFF) d = 24'hFF_FFFF;
            it.offset = d[23:0];
        end else if (r < 70) begin
            d = (target > 24'hFF_FFFF) ? 24'hFF_FFFF : target;
            it.offset = 24'($urandom_range(0, int'(d)));
        end else begin
            it.offset = 24'($urandom);
        end
        return it;
    endfunction

    task automatic send(gate_item_t it, int unsigned gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid             <= 1'b1;
        s_op                <= it.op;
        s_now_ms            <= it.now;
        s_distance          <= it.offset;
        s_avg_distance      <= it.avg;
        s_guiding_active    <= it.guiding;
        s_paused            <= it.paused;
        s_settling          <= it.settling;
        s_error_frame_count <= it.frames;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        // read back the register just written
        if (prdata !== sb.get_reg(idx)) begin
            sb.errors++;
            if (sb.errors <= 10)
                $display("register read mismatch at %0t: idx=%0d exp=%h got=%h",
                         $realtime, idx, sb.get_reg(idx), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic setup_phase(int p);
        logic [31:0] en, tol, ftol, wms, minf;
        case (p)
            0: begin en = 1; tol = 256;   ftol = 512;   wms = 5000;  minf = 10;  end
            1: begin en = 1; tol = 0;     ftol = 0;     wms = 0;     minf = 0;   end
            2: begin en = 1; tol = 65535; ftol = 65535; wms = 65535; minf = 255; end
            3: begin en = 0; tol = 300;   ftol = 384;   wms = 2000;  minf = 5;   end
            4: begin en = 1; tol = 192;   ftol = 640;   wms = 300;   minf = 1;   end
            default: begin
                en   = $urandom_range(0, 1);
                tol  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(64, 1024);
                ftol = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(64, 1024);
                wms  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8000);
                minf = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
            end
        endcase
        drain();
        write_reg(REG_JUMP_EN, en);
        write_reg(REG_JUMP_TOL, tol);
        write_reg(REG_FORCED_TOL, ftol);
        write_reg(REG_WAIT_MS, wms);
        write_reg(REG_MIN_FRAMES, minf);
    endtask

    initial begin
        #8_000_000;
        $display("jump_reject_recovery_fsm_test: errors");
        $finish;
    end

    initial begin
        aresetn             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        s_valid             = 1'b0;
        s_op                = OP_CHECK;
        s_now_ms            = '0;
        s_distance          = '0;
        s_avg_distance      = '0;
        s_guiding_active    = 1'b0;
        s_paused            = 1'b0;
        s_settling          = 1'b0;
        s_error_frame_count = '0;
        no_idle             = 1'b0;
        clock_ms            = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: jump check off, so tolerance is infinite
        send(mk(OP_CHECK, 1000, 24'hFF_FFFF, 0, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 1000, 24'hFF_FFFF, 0, 0, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 1000, 24'hFF_FFFF, 0, 1, 1, 0, 10), idle_len());
        send(mk(OP_CHECK, 1000, 24'hFF_FFFF, 0, 1, 0, 1, 10), idle_len());
        send(mk(OP_CHECK, 1000, 24'hFF_FFFF, 0, 1, 0, 0, 9), idle_len());
        send(mk(OP_CHECK, 1000, 0, 24'hFF_FFFF, 1, 0, 0, 16'hFFFF), idle_len());

        drain();
        write_reg(REG_JUMP_EN, 1);
        write_reg(REG_JUMP_TOL, 256);
        // zero average: zero offset is small, any other is large
        send(mk(OP_CHECK, 2000, 0, 0, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 2000, 1, 0, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 6999, 5, 0, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 3000, 0, 0, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 10000, 200, 100, 1, 0, 0, 10), idle_len());
        // deadline reached exactly
        send(mk(OP_CHECK, 15000, 200, 100, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 16000, 200, 100, 1, 0, 0, 10), idle_len());
        send(mk(OP_ACTIVATE, 16500, 0, 0, 0, 0, 0, 0), idle_len());
        send(mk(OP_CHECK, 17000, 100, 100, 1, 0, 0, 10), idle_len());
        send(mk(OP_ACTIVATE, 18000, 0, 0, 0, 0, 0, 0), idle_len());
        send(mk(OP_ACTIVATE, 19000, 24'hFF_FFFF, 24'hFF_FFFF, 1, 1, 1, 16'hFFFF), idle_len());
        send(mk(OP_CHECK, 20000, 200, 100, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 21000, 24'hFF_FFFF, 24'hFF_FFFF, 1, 0, 0, 16'hFFFF), idle_len());

        drain();
        write_reg(REG_JUMP_TOL, 65535);
        send(mk(OP_CHECK, 22000, 24'hFF_FFFF, 24'hFF_FFFF, 1, 0, 0, 16'hFFFF), idle_len());
        // deadline wraps past the top of the time range
        send(mk(OP_ACTIVATE, 48'hFFFF_FFFF_FF00, 0, 0, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 48'hFFFF_FFFF_FF80, 24'hFF_FFFF, 1, 1, 0, 0, 10), idle_len());
        // recovering back to guiding keeps the forced tolerance
        send(mk(OP_CHECK, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 1, 1, 0, 1, 10), idle_len());
        send(mk(OP_CHECK, 100, 3, 1, 1, 0, 0, 10), idle_len());
        send(mk(OP_CHECK, 200, 2, 1, 1, 0, 0, 10), idle_len());

        clock_ms = 30000;
        for (int p = 0; p < 9; p++) begin
            setup_phase(p);
            no_idle = (p == 4);
            for (int i = 0; i < 150; i++) begin
                send(rand_item(), idle_len());
                if (p == 3 && i == 75) drain();
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (2 * LATENCY) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("jump_reject_recovery_fsm_test: clean");
        end else begin
            $display("jump_reject_recovery_fsm_test: errors");
        end
        $finish;
    end

endmodule
